>>> hdl/scalar_kalman_filter_top_defines.svh
// Assertion macros for the scalar Kalman filter
`ifndef SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH

// plain property, checked outside reset
`define SKF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from one cycle to the next
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/skf_pkg.sv
// Package: widths, reset values, codes and types of the scalar Kalman filter
`default_nettype none
package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = 16;

  localparam int EST_W  = 32;
  localparam int UNC_W  = 31;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 2;
  localparam int K_W    = GAIN_BITS + 1;
  localparam int DIFF_W = EST_W + 1;
  localparam int PROD_W = K_W + 1 + DIFF_W;
  localparam int DEN_W  = UNC_W + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int DIV_STEPS = K_W;
  localparam int CNT_W  = $clog2(DIV_STEPS);
  localparam int SUM_W  = PROD_W - GAIN_BITS + 1;

  localparam logic [K_W-1:0]   GAIN_ONE     = K_W'(64'd1 << GAIN_BITS);
  localparam logic [UNC_W-1:0] RESET_UNC    = UNC_W'(64'd1 << FRAC_BITS);
  localparam logic [UNC_W-1:0] RESET_PNOISE = UNC_W'((64'd655 << FRAC_BITS) >> 16);
  localparam logic [EST_W-1:0] RESET_EST    = '0;

  typedef enum logic [IDX_W-1:0] {
    CFG_INIT_EST   = 2'd0,
    CFG_INIT_UNC   = 2'd1,
    CFG_MEAS_NOISE = 2'd2,
    CFG_PROC_NOISE = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_UNC,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

>>> hdl/skf_intf.sv
// Channel interfaces: sample input, estimate output, register writes
`default_nettype none
interface skf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [skf_pkg::EST_W-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface skf_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [skf_pkg::EST_W-1:0] estimate;

  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

interface skf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [skf_pkg::IDX_W-1:0]  index;
  logic [skf_pkg::CFG_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/skf_div.sv
// Restoring divider, one quotient bit per cycle, for the gain fraction
`default_nettype none
module skf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [skf_pkg::UNC_W-1:0]    num_i,
  input  logic [skf_pkg::DEN_W-1:0]    den_i,
  output logic [skf_pkg::K_W-1:0]      quo_o,
  output skf_pkg::div_stat_t           stat_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [skf_pkg::CNT_W-1:0]   cnt_q;
  logic [skf_pkg::REM_W-1:0]   rem_q;
  logic [skf_pkg::DEN_W-1:0]   den_q;
  logic [skf_pkg::K_W-1:0]     quo_q;
  logic [skf_pkg::REM_W-1:0]   trial;
  logic [skf_pkg::REM_W-1:0]   den_ext;
  logic                        take;
  logic [skf_pkg::REM_W-1:0]   rem_d;

  always_comb begin
    den_ext = {1'b0, den_q};
    trial   = (cnt_q == '0) ? rem_q : {rem_q[skf_pkg::REM_W-2:0], 1'b0};
    take    = (trial >= den_ext);
    rem_d   = take ? (trial - den_ext) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= skf_pkg::REM_W'(num_i);
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[skf_pkg::K_W-2:0], take};
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

>>> hdl/skf_mul.sv
// Shared registered multiplier: unsigned gain times signed operand
`default_nettype none
module skf_mul (
  input  logic                               clk_i,
  input  logic [skf_pkg::K_W-1:0]            a_i,
  input  logic signed [skf_pkg::DIFF_W-1:0]  b_i,
  output logic signed [skf_pkg::PROD_W-1:0]  p_o
);

  logic signed [skf_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= $signed({1'b0, a_i}) * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> hdl/scalar_kalman_filter_top.sv
// Top level: sequencer, state and registers of the scalar Kalman filter
//
// Use: words arrive on in_i (kind, sample) with valid/ready; each word gives
// one estimate word on out_o. Registers are written through cfg_i (index,
// data), which is always ready; write them only while the block is idle.
// A clear word reloads estimate and uncertainty from the registers and its
// result passes through the done state to the output register. For a sample
// word, a 17-step restoring divider forms the gain one bit per cycle, then
// one shared multiplier forms the estimate and uncertainty products one
// after the other. in_i is not ready while a word is in work, so a new
// word is taken only once the last one has left the sequencer.
// The result waits in an output register; the next word is accepted while
// it waits. If the receiver stalls, a finished word holds in the sequencer
// until the output register frees, and input stays stalled meanwhile.
// Reset: registers take their reset values, the estimate is 0 and the
// uncertainty 1.0, and no output word is pending.
`default_nettype none
`include "scalar_kalman_filter_top_defines.svh"
module scalar_kalman_filter_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  skf_in_if.sink       in_i,
  skf_out_if.source    out_o,
  skf_cfg_if.sink      cfg_i
);

  skf_pkg::state_e state_q, state_d;

  logic signed [skf_pkg::EST_W-1:0]  init_est_q;
  logic [skf_pkg::UNC_W-1:0]         init_unc_q;
  logic [skf_pkg::UNC_W-1:0]         mnoise_q;
  logic [skf_pkg::UNC_W-1:0]         pnoise_q;

  logic signed [skf_pkg::EST_W-1:0]  est_q, est_d;
  logic [skf_pkg::UNC_W-1:0]         unc_q, unc_d;
  logic signed [skf_pkg::EST_W-1:0]  sample_q, sample_d;
  logic [skf_pkg::K_W-1:0]           k_q, k_d;
  logic                              out_valid_q, out_valid_d;
  logic signed [skf_pkg::EST_W-1:0]  out_est_q, out_est_d;

  logic                              in_accept;
  logic                              div_start;
  logic [skf_pkg::DEN_W-1:0]         den;
  logic [skf_pkg::K_W-1:0]           quo;
  skf_pkg::div_stat_t                div_stat;
  logic [skf_pkg::K_W-1:0]           mul_a;
  logic signed [skf_pkg::DIFF_W-1:0] mul_b;
  logic signed [skf_pkg::PROD_W-1:0] prod;
  logic signed [skf_pkg::SUM_W-1:0]  est_sum;
  logic [skf_pkg::DEN_W-1:0]         unc_sum;

  assign den       = {1'b0, unc_q} + {1'b0, mnoise_q};
  assign in_accept = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (unc_q),
    .den_i   (den),
    .quo_o   (quo),
    .stat_o  (div_stat)
  );

  skf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    est_sum = skf_pkg::SUM_W'(est_q)
            + skf_pkg::SUM_W'($signed(prod[skf_pkg::PROD_W-1:skf_pkg::GAIN_BITS]));
    unc_sum = skf_pkg::DEN_W'(prod[skf_pkg::GAIN_BITS +: skf_pkg::UNC_W])
            + {1'b0, pnoise_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_est_q <= skf_pkg::RESET_EST;
      init_unc_q <= skf_pkg::RESET_UNC;
      mnoise_q   <= skf_pkg::RESET_UNC;
      pnoise_q   <= skf_pkg::RESET_PNOISE;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        skf_pkg::CFG_INIT_EST:   init_est_q <= cfg_i.data;
        skf_pkg::CFG_INIT_UNC:   init_unc_q <= cfg_i.data[skf_pkg::UNC_W-1:0];
        skf_pkg::CFG_MEAS_NOISE: mnoise_q   <= cfg_i.data[skf_pkg::UNC_W-1:0];
        skf_pkg::CFG_PROC_NOISE: pnoise_q   <= cfg_i.data[skf_pkg::UNC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skf_pkg::ST_IDLE;
      est_q       <= skf_pkg::RESET_EST;
      unc_q       <= skf_pkg::RESET_UNC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      est_q       <= est_d;
      unc_q       <= unc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    k_q       <= k_d;
    out_est_q <= out_est_d;
  end

  always_comb begin
    state_d     = state_q;
    est_d       = est_q;
    unc_d       = unc_q;
    sample_d    = sample_q;
    k_d         = k_q;
    out_est_d   = out_est_q;
    out_valid_d = out_valid_q && !out_o.ready;
    in_i.ready  = 1'b0;
    div_start   = 1'b0;
    mul_a       = k_q;
    mul_b       = skf_pkg::DIFF_W'(sample_q) - skf_pkg::DIFF_W'(est_q);

    case (state_q)
      skf_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_accept) begin
          if (in_i.kind == skf_pkg::KIND_CLEAR) begin
            est_d   = init_est_q;
            unc_d   = init_unc_q;
            state_d = skf_pkg::ST_DONE;
          end else begin
            sample_d  = in_i.sample;
            div_start = 1'b1;
            state_d   = skf_pkg::ST_DIV;
          end
        end
      end
      skf_pkg::ST_DIV: begin
        if (div_stat.done) begin
          k_d     = (den == '0) ? '0 : quo;
          state_d = skf_pkg::ST_MUL_EST;
        end
      end
      skf_pkg::ST_MUL_EST: begin
        state_d = skf_pkg::ST_MUL_UNC;
      end
      skf_pkg::ST_MUL_UNC: begin
        mul_a = skf_pkg::GAIN_ONE - k_q;
        mul_b = skf_pkg::DIFF_W'(unc_q);
        if (est_sum[skf_pkg::SUM_W-1:skf_pkg::EST_W-1] == '0 ||
            est_sum[skf_pkg::SUM_W-1:skf_pkg::EST_W-1] == '1) begin
          est_d = est_sum[skf_pkg::EST_W-1:0];
        end else if (est_sum[skf_pkg::SUM_W-1]) begin
          est_d = {1'b1, {(skf_pkg::EST_W-1){1'b0}}};
        end else begin
          est_d = {1'b0, {(skf_pkg::EST_W-1){1'b1}}};
        end
        state_d = skf_pkg::ST_UPD;
      end
      skf_pkg::ST_UPD: begin
        unc_d   = unc_sum[skf_pkg::UNC_W] ? '1 : unc_sum[skf_pkg::UNC_W-1:0];
        state_d = skf_pkg::ST_DONE;
      end
      skf_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_est_d   = est_q;
          out_valid_d = 1'b1;
          state_d     = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = skf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.estimate = out_est_q;

  `SKF_ASSERT(a_ready_div_idle, !in_i.ready || !div_stat.busy, "input ready while divider busy")
  `SKF_ASSERT(a_div_done_state, !div_stat.done || state_q == skf_pkg::ST_DIV, "divider done outside divide")
  `SKF_ASSERT_NEXT(a_accept_drops_ready, in_accept, !in_i.ready, "ready held after accepted word")

endmodule
`default_nettype wire

>>> tb/sv/scalar_kalman_filter_top_test.sv
// Self-checking testbench for the scalar Kalman filter: directed and random words against a predictor
`default_nettype none
module scalar_kalman_filter_top_test;

  localparam longint EST_MAX = 64'sd2147483647;
  localparam longint EST_MIN = -64'sd2147483648;
  localparam longint UNC_MAX = 64'sd2147483647;

  class kalman_tracker;
    logic signed [skf_pkg::EST_W-1:0] start_estimate;
    logic [skf_pkg::UNC_W-1:0]        start_uncertainty;
    logic [skf_pkg::UNC_W-1:0]        meas_noise;
    logic [skf_pkg::UNC_W-1:0]        proc_noise;
    logic signed [skf_pkg::EST_W-1:0] estimate;
    logic [skf_pkg::UNC_W-1:0]        uncertainty;
    logic signed [skf_pkg::EST_W-1:0] expected_estimates[$];
    int unsigned                      failures;

    function new();
      start_estimate    = skf_pkg::RESET_EST;
      start_uncertainty = skf_pkg::RESET_UNC;
      meas_noise        = skf_pkg::RESET_UNC;
      proc_noise        = skf_pkg::RESET_PNOISE;
      estimate          = start_estimate;
      uncertainty       = start_uncertainty;
      failures          = 0;
    endfunction

    function void set_register(skf_pkg::cfg_idx_e idx, logic [skf_pkg::CFG_W-1:0] data);
      case (idx)
        skf_pkg::CFG_INIT_EST:   start_estimate    = data;
        skf_pkg::CFG_INIT_UNC:   start_uncertainty = data[skf_pkg::UNC_W-1:0];
        skf_pkg::CFG_MEAS_NOISE: meas_noise        = data[skf_pkg::UNC_W-1:0];
        skf_pkg::CFG_PROC_NOISE: proc_noise        = data[skf_pkg::UNC_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_word(skf_pkg::kind_e kind, logic signed [skf_pkg::EST_W-1:0] sample);
      longint eu;
      longint den;
      longint gain;
      longint diff;
      longint moved;
      longint nu;
      if (kind == skf_pkg::KIND_CLEAR) begin
        estimate    = start_estimate;
        uncertainty = start_uncertainty;
      end else begin
        eu   = {33'd0, uncertainty};
        den  = eu + {33'd0, meas_noise};
        gain = (den == 0) ? 64'sd0 : (eu << skf_pkg::GAIN_BITS) / den;
        if (gain > (64'sd1 << skf_pkg::GAIN_BITS)) gain = 64'sd1 << skf_pkg::GAIN_BITS;
        diff  = longint'(sample) - longint'(estimate);
        moved = longint'(estimate) + ((gain * diff) >>> skf_pkg::GAIN_BITS);
        if (moved > EST_MAX) moved = EST_MAX;
        if (moved < EST_MIN) moved = EST_MIN;
        estimate = moved[skf_pkg::EST_W-1:0];
        nu = ((((64'sd1 << skf_pkg::GAIN_BITS) - gain) * eu) >>> skf_pkg::GAIN_BITS)
           + {33'd0, proc_noise};
        if (nu > UNC_MAX) nu = UNC_MAX;
        uncertainty = nu[skf_pkg::UNC_W-1:0];
      end
      expected_estimates.push_back(estimate);
    endfunction

    function void check_estimate(logic signed [skf_pkg::EST_W-1:0] got);
      logic signed [skf_pkg::EST_W-1:0] want;
      if (expected_estimates.size() == 0) begin
        $error("estimate: expected none, actual %0d", got);
        failures++;
      end else begin
        want = expected_estimates.pop_front();
        if (got !== want) begin
          $error("estimate: expected %0d, actual %0d", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  skf_in_if  in_if ();
  skf_out_if out_if ();
  skf_cfg_if cfg_if ();

  scalar_kalman_filter_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  kalman_tracker tracker = new();
  int unsigned   send_idle_pct = 30;
  int unsigned   recv_idle_pct = 30;
  logic          stall_request = 1'b0;
  logic          hold_off = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) tracker.check_estimate(out_if.estimate);
  end

  // starve the output for a long stretch so the block backs up
  initial begin
    wait (stall_request);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #(20 * 2_000_000);
    $display("scalar_kalman_filter_top: mismatch");
    $finish;
  end

  task automatic send_word(skf_pkg::kind_e kind, logic signed [skf_pkg::EST_W-1:0] sample);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= kind;
    in_if.sample <= sample;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.take_word(kind, sample);
    @(negedge clk_i);
  endtask

  task automatic write_register(skf_pkg::cfg_idx_e idx, logic [skf_pkg::CFG_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.set_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_settings(logic [skf_pkg::CFG_W-1:0] init_est,
                               logic [skf_pkg::CFG_W-1:0] init_unc,
                               logic [skf_pkg::CFG_W-1:0] mnoise,
                               logic [skf_pkg::CFG_W-1:0] pnoise);
    write_register(skf_pkg::CFG_INIT_EST, init_est);
    write_register(skf_pkg::CFG_INIT_UNC, init_unc);
    write_register(skf_pkg::CFG_MEAS_NOISE, mnoise);
    write_register(skf_pkg::CFG_PROC_NOISE, pnoise);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (tracker.expected_estimates.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [skf_pkg::CFG_W-1:0] pick_variance();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1 << 17);
      3: return $urandom & 32'h7FFF_FFFF;
      default: return $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  function automatic logic [skf_pkg::CFG_W-1:0] pick_start_estimate();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [skf_pkg::EST_W-1:0] pick_sample(
      logic signed [skf_pkg::EST_W-1:0] level, int unsigned spread);
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return level + 32'($urandom_range(0, spread)) - 32'(spread / 2);
    endcase
  endfunction

  task automatic run_phase(int unsigned count);
    logic signed [skf_pkg::EST_W-1:0] level;
    int unsigned                      spread;
    level  = $urandom;
    spread = 1 << $urandom_range(0, 24);
    load_settings(pick_start_estimate(), pick_variance(), pick_variance(), pick_variance());
    send_word(skf_pkg::KIND_CLEAR, $urandom);
    repeat (count) begin
      if ($urandom_range(0, 11) == 0) send_word(skf_pkg::KIND_CLEAR, $urandom);
      else send_word(skf_pkg::KIND_SAMPLE, pick_sample(level, spread));
    end
    settle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.kind    = skf_pkg::KIND_SAMPLE;
    in_if.sample  = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = skf_pkg::CFG_INIT_EST;
    cfg_if.data   = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_word(skf_pkg::KIND_SAMPLE, 32'sh7FFF_FFFF);
    send_word(skf_pkg::KIND_SAMPLE, 32'sh8000_0000);
    send_word(skf_pkg::KIND_CLEAR, 32'sh7FFF_FFFF);
    send_word(skf_pkg::KIND_SAMPLE, 32'sh0000_0000);
    send_word(skf_pkg::KIND_SAMPLE, -32'sd1);
    send_word(skf_pkg::KIND_SAMPLE, 32'sh1234_5678);
    settle();

    // unity gain, uncertainty held at its maximum
    load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    send_word(skf_pkg::KIND_CLEAR, 32'sh0000_0000);
    send_word(skf_pkg::KIND_SAMPLE, 32'sh7FFF_FFFF);
    send_word(skf_pkg::KIND_SAMPLE, 32'sh8000_0000);
    send_word(skf_pkg::KIND_SAMPLE, 32'sh0000_0005);
    settle();

    // zero denominator holds the estimate
    load_settings(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(skf_pkg::KIND_CLEAR, -32'sd1);
    send_word(skf_pkg::KIND_SAMPLE, 32'sh8000_0000);
    send_word(skf_pkg::KIND_SAMPLE, 32'sh0000_0000);
    settle();

    // half gain, rounding toward minus infinity
    load_settings(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(skf_pkg::KIND_CLEAR, 32'sh0000_0000);
    send_word(skf_pkg::KIND_SAMPLE, -32'sd1);
    send_word(skf_pkg::KIND_SAMPLE, 32'sh0000_0001);
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          stall_request = 1'b1;
        end
      endcase
      for (int p = 0; p < 4; p++) run_phase(132);
    end

    settle();
    repeat (40) @(negedge clk_i);
    if (tracker.failures == 0 && tracker.expected_estimates.size() == 0) begin
      $display("scalar_kalman_filter_top: match");
    end else begin
      $display("scalar_kalman_filter_top: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
